/* rtl/core/two_link_forward_kinematics_top_macros.svh */
// ----------------------------------------------------------------------------
// Two-link forward kinematics assertion macros
// Check macros clocked on clock and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef TWO_LINK_FORWARD_KINEMATICS_TOP_MACROS_SVH
`define TWO_LINK_FORWARD_KINEMATICS_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

`define TLFK_ASSERT(lbl, cond) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("tlfk check failed");

`define TLFK_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("tlfk implication failed");

`define TLFK_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("tlfk next-cycle check failed");

`else

`define TLFK_ASSERT(lbl, cond)
`define TLFK_ASSERT_IMP(lbl, ante, cons)
`define TLFK_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

/* rtl/core/tlfk_pkg.sv */
// ----------------------------------------------------------------------------
// tlfk_pkg
// Shared types, constants and arithmetic helpers of the two-link kinematics.
// ----------------------------------------------------------------------------
package tlfk_pkg;

   localparam int ANGLE_BITS   = 16;
   localparam int ANGLE_W      = 16;
   localparam int PHASE_W      = 32;
   localparam int PHASE_SHIFT  = PHASE_W - ANGLE_BITS;

   localparam int CORDIC_STEPS = 24;
   localparam int STEP_W       = $clog2(CORDIC_STEPS);

   localparam int VEC_W   = 34;
   localparam int ANG_W   = 33;
   localparam int RND_W   = VEC_W - 14;
   localparam int TRIG_W  = 17;
   localparam int LEN_W   = 16;
   localparam int PROD_W  = 2 * TRIG_W;
   localparam int SUM_W   = PROD_W + 2;
   localparam int ACC_W   = SUM_W + 1;
   localparam int POS_W   = 18;
   localparam int OUT_RND_W = ACC_W - 15;

   localparam int CSR_IDX_W = 8;
   localparam logic [CSR_IDX_W-1:0] CSR_UPPER_LEN = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LOWER_LEN = 8'd1;
   localparam logic [LEN_W-1:0]     LENGTH_RESET  = 16'd256;

   localparam int QUEUE_DEPTH = 32;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam logic [QUEUE_AW:0] QUEUE_FULL = (QUEUE_AW + 1)'(QUEUE_DEPTH);

   localparam logic signed [VEC_W-1:0]     CORDIC_GAIN = 34'sd652032874;
   localparam logic signed [RND_W-1:0]     TRIG_HI     = 20'sd32768;
   localparam logic signed [RND_W-1:0]     TRIG_LO     = -20'sd32768;
   localparam logic signed [OUT_RND_W-1:0] X_HI        = 22'sd131070;
   localparam logic signed [OUT_RND_W-1:0] X_LO        = -22'sd131070;
   localparam logic signed [OUT_RND_W-1:0] Y_HI        = 22'sd262140;

   localparam logic signed [ANG_W-1:0] ATAN_TURN [CORDIC_STEPS] = '{
      33'sh20000000, 33'sh12E4051E, 33'sh09FB385B, 33'sh051111D4,
      33'sh028B0D43, 33'sh0145D7E1, 33'sh00A2F61E, 33'sh00517C55,
      33'sh0028BE53, 33'sh00145F2F, 33'sh000A2F98, 33'sh000517CC,
      33'sh00028BE6, 33'sh000145F3, 33'sh0000A2FA, 33'sh0000517D,
      33'sh000028BE, 33'sh0000145F, 33'sh00000A30, 33'sh00000518,
      33'sh0000028C, 33'sh00000146, 33'sh000000A3, 33'sh00000051
   };

   typedef struct packed {
      logic signed [VEC_W-1:0] x;
      logic signed [VEC_W-1:0] y;
      logic signed [ANG_W-1:0] z;
      logic [1:0]              quad;
   } lane_type;

   typedef struct packed {
      logic     valid;
      lane_type hip;
      lane_type foot;
   } cordic_stage_type;

   typedef struct packed {
      logic signed [TRIG_W-1:0] s;
      logic signed [TRIG_W-1:0] c;
   } trig_type;

   typedef struct packed {
      logic signed [POS_W-1:0] x_position;
      logic [POS_W-1:0]        y_position;
   } rsp_item_type;

   typedef struct packed {
      logic         valid;
      rsp_item_type item;
   } rsp_stage_type;

   typedef struct packed {
      logic [QUEUE_AW:0] count;
      logic              full;
   } queue_status_type;

   function automatic lane_type lane_init(input logic [PHASE_W-1:0] phase);
      lane_type r;
      r.x    = CORDIC_GAIN;
      r.y    = '0;
      r.z    = $signed({3'b000, phase[PHASE_W-3:0]});
      r.quad = phase[PHASE_W-1:PHASE_W-2];
      return r;
   endfunction

   function automatic lane_type cordic_step(input lane_type a,
                                            input logic [STEP_W-1:0] idx);
      lane_type r;
      logic signed [VEC_W-1:0] dx;
      logic signed [VEC_W-1:0] dy;
      dx = a.y >>> idx;
      dy = a.x >>> idx;
      r  = a;
      if (!a.z[ANG_W-1]) begin
         r.x = a.x - dx;
         r.y = a.y + dy;
         r.z = a.z - ATAN_TURN[idx];
      end else begin
         r.x = a.x + dx;
         r.y = a.y - dy;
         r.z = a.z + ATAN_TURN[idx];
      end
      return r;
   endfunction

   // round half up to Q1.15, clamp to +/-1.0
   function automatic logic signed [TRIG_W-1:0] to_q15(input logic signed [VEC_W-1:0] v);
      logic signed [VEC_W:0]   t;
      logic signed [RND_W-1:0] r;
      t = $signed({v[VEC_W-1], v}) + (VEC_W + 1)'(16384);
      r = $signed(t[VEC_W:15]);
      if (r > TRIG_HI) begin
         r = TRIG_HI;
      end else if (r < TRIG_LO) begin
         r = TRIG_LO;
      end
      return TRIG_W'(r);
   endfunction

   function automatic trig_type lane_trig(input lane_type a);
      trig_type r;
      logic signed [TRIG_W-1:0] c;
      logic signed [TRIG_W-1:0] s;
      c = to_q15(a.x);
      s = to_q15(a.y);
      case (a.quad)
         2'd0: begin
            r.c = c;
            r.s = s;
         end
         2'd1: begin
            r.c = -s;
            r.s = c;
         end
         2'd2: begin
            r.c = -c;
            r.s = -s;
         end
         default: begin
            r.c = s;
            r.s = -c;
         end
      endcase
      return r;
   endfunction

endpackage

/* rtl/core/tlfk_ifs.sv */
// ----------------------------------------------------------------------------
// tlfk channel interfaces
// Valid/ready channels for requests, responses and register writes.
// ----------------------------------------------------------------------------
interface tlfk_req_if;
   import tlfk_pkg::*;
   logic               valid;
   logic               ready;
   logic [ANGLE_W-1:0] hip_angle;
   logic [ANGLE_W-1:0] knee_angle;
   modport source (output valid, hip_angle, knee_angle, input ready);
   modport sink (input valid, hip_angle, knee_angle, output ready);
endinterface

interface tlfk_rsp_if;
   import tlfk_pkg::*;
   logic                    valid;
   logic                    ready;
   logic signed [POS_W-1:0] x_position;
   logic [POS_W-1:0]        y_position;
   modport source (output valid, x_position, y_position, input ready);
   modport sink (input valid, x_position, y_position, output ready);
endinterface

interface tlfk_csr_if;
   import tlfk_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] reg_index;
   logic [LEN_W-1:0]     write_data;
   modport source (output valid, reg_index, write_data, input ready);
   modport sink (input valid, reg_index, write_data, output ready);
endinterface

/* rtl/core/two_link_forward_kinematics_top.sv */
// ----------------------------------------------------------------------------
// two_link_forward_kinematics_top
// Foot position of a two-link planar leg from hip and knee binary angles.
// ----------------------------------------------------------------------------
// Usage:
//   req_bus carries one request per handshake: hip_angle and knee_angle,
//   16-bit binary angles (65536 = one turn). rsp_bus returns one result per
//   request, in order: x_position (signed) and y_position (down from the
//   full-reach top). csr_bus writes the thigh length (index 0) and the
//   lower leg length (index 1); a zero write or an unknown index is dropped.
//   Write lengths only while no request is in flight.
//   Throughput is one request per clock while req_bus.ready is high. A
//   request passes one input register, 24 CORDIC cells, four post stages
//   (fold, multiply, sum, round) and the response queue to rsp_bus.valid.
//   Up to 32 requests may be in flight; a 32-entry response queue holds
//   results while the receiver stalls, and req_bus.ready drops only when
//   32 requests are outstanding.
//   Reset clears the pipeline and queue and sets both lengths to 256.
// ----------------------------------------------------------------------------
`include "two_link_forward_kinematics_top_macros.svh"

module two_link_forward_kinematics_top (
   input  logic       clock,
   input  logic       reset,
   tlfk_req_if.sink   req_bus,
   tlfk_rsp_if.source rsp_bus,
   tlfk_csr_if.sink   csr_bus
);
   import tlfk_pkg::*;

   logic [LEN_W-1:0] thigh_ff;
   logic [LEN_W-1:0] thigh_in;
   logic [LEN_W-1:0] lower_ff;
   logic [LEN_W-1:0] lower_in;
   logic             csr_wr;
   logic             csr_zero_wr;

   logic [QUEUE_AW:0] outstanding_ff;
   logic [QUEUE_AW:0] outstanding_in;
   logic              req_take;
   logic              rsp_take;

   logic [PHASE_W-1:0] ph_hip;
   logic [PHASE_W-1:0] ph_knee;
   logic [PHASE_W-1:0] ph_foot;
   logic               in_valid_ff;
   lane_type           in_hip_ff;
   lane_type           in_foot_ff;

   cordic_stage_type chain [CORDIC_STEPS+1];
   rsp_stage_type    post_out;
   queue_status_type q_status;

   // configuration
   assign csr_bus.ready = 1'b1;
   assign csr_wr        = csr_bus.valid && (csr_bus.write_data != '0);
   assign csr_zero_wr   = csr_bus.valid && (csr_bus.write_data == '0);

   always_comb begin
      thigh_in = thigh_ff;
      lower_in = lower_ff;
      if (csr_wr) begin
         case (csr_bus.reg_index)
            CSR_UPPER_LEN: thigh_in = csr_bus.write_data;
            CSR_LOWER_LEN: lower_in = csr_bus.write_data;
            default: begin
               thigh_in = thigh_ff;
               lower_in = lower_ff;
            end
         endcase
      end
   end

   // credit count covers pipeline plus queue
   assign req_bus.ready = (outstanding_ff < QUEUE_FULL);
   assign req_take      = req_bus.valid && req_bus.ready;
   assign rsp_take      = rsp_bus.valid && rsp_bus.ready;

   always_comb begin
      outstanding_in = outstanding_ff;
      if (req_take && !rsp_take) begin
         outstanding_in = outstanding_ff + 1'b1;
      end else if (!req_take && rsp_take) begin
         outstanding_in = outstanding_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thigh_ff       <= LENGTH_RESET;
         lower_ff       <= LENGTH_RESET;
         outstanding_ff <= '0;
         in_valid_ff    <= 1'b0;
      end else begin
         thigh_ff       <= thigh_in;
         lower_ff       <= lower_in;
         outstanding_ff <= outstanding_in;
         in_valid_ff    <= req_take;
      end
   end

   // input stage
   always_comb begin
      ph_hip  = PHASE_W'(req_bus.hip_angle) << PHASE_SHIFT;
      ph_knee = PHASE_W'(req_bus.knee_angle) << PHASE_SHIFT;
      ph_foot = ph_hip + ph_knee;
   end

   always_ff @(posedge clock) begin
      in_hip_ff  <= lane_init(ph_hip);
      in_foot_ff <= lane_init(ph_foot);
   end

   assign chain[0].valid = in_valid_ff;
   assign chain[0].hip   = in_hip_ff;
   assign chain[0].foot  = in_foot_ff;

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
      tlfk_cordic_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .step_idx   (STEP_W'(i)),
         .prev_stage (chain[i]),
         .next_stage (chain[i+1])
      );
   end

   tlfk_post u_post (
      .clock      (clock),
      .reset      (reset),
      .cordic_out (chain[CORDIC_STEPS]),
      .upper_len  (thigh_ff),
      .lower_len  (lower_ff),
      .result     (post_out)
   );

   tlfk_rsp_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr      (post_out),
      .rsp_bus (rsp_bus),
      .status  (q_status)
   );

   `TLFK_ASSERT(a_credit_bound, outstanding_ff <= QUEUE_FULL)
   `TLFK_ASSERT(a_queue_within_credit, q_status.count <= outstanding_ff)
   `TLFK_ASSERT_IMP(a_queue_no_overflow, post_out.valid, !q_status.full)
   `TLFK_ASSERT_NEXT(a_zero_len_dropped, csr_zero_wr, $stable(thigh_ff) && $stable(lower_ff))

endmodule

/* rtl/core/tlfk_cordic_cell.sv */
// ----------------------------------------------------------------------------
// tlfk_cordic_cell
// One registered CORDIC rotation step for the hip and foot lanes.
// ----------------------------------------------------------------------------
module tlfk_cordic_cell (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [tlfk_pkg::STEP_W-1:0]    step_idx,
   input  tlfk_pkg::cordic_stage_type     prev_stage,
   output tlfk_pkg::cordic_stage_type     next_stage
);
   import tlfk_pkg::*;

   logic     valid_ff;
   lane_type hip_ff;
   lane_type hip_in;
   lane_type foot_ff;
   lane_type foot_in;

   always_comb begin
      hip_in  = cordic_step(prev_stage.hip, step_idx);
      foot_in = cordic_step(prev_stage.foot, step_idx);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= prev_stage.valid;
      end
   end

   always_ff @(posedge clock) begin
      hip_ff  <= hip_in;
      foot_ff <= foot_in;
   end

   assign next_stage.valid = valid_ff;
   assign next_stage.hip   = hip_ff;
   assign next_stage.foot  = foot_ff;

endmodule

/* rtl/core/tlfk_post.sv */
// ----------------------------------------------------------------------------
// tlfk_post
// Quadrant fold, length products, sums and final rounding to positions.
// ----------------------------------------------------------------------------
module tlfk_post (
   input  logic                          clock,
   input  logic                          reset,
   input  tlfk_pkg::cordic_stage_type    cordic_out,
   input  logic [tlfk_pkg::LEN_W-1:0]    upper_len,
   input  logic [tlfk_pkg::LEN_W-1:0]    lower_len,
   output tlfk_pkg::rsp_stage_type       result
);
   import tlfk_pkg::*;

   // stage A: trig values
   logic     a_valid_ff;
   trig_type hip_trig_ff;
   trig_type foot_trig_ff;

   // stage B: products
   logic                     b_valid_ff;
   logic signed [PROD_W-1:0] px1_ff;
   logic signed [PROD_W-1:0] px2_ff;
   logic signed [PROD_W-1:0] py1_ff;
   logic signed [PROD_W-1:0] py2_ff;
   logic [LEN_W:0]           lsum_ff;
   logic signed [PROD_W-1:0] px1_in;
   logic signed [PROD_W-1:0] px2_in;
   logic signed [PROD_W-1:0] py1_in;
   logic signed [PROD_W-1:0] py2_in;
   logic signed [LEN_W:0]    l1s;
   logic signed [LEN_W:0]    l2s;

   // stage C: sums
   logic                    c_valid_ff;
   logic signed [SUM_W-1:0] xr_ff;
   logic signed [SUM_W-1:0] qs_ff;
   logic [LEN_W:0]          base_ff;

   // stage D: rounded result
   logic                        d_valid_ff;
   rsp_item_type                item_ff;
   rsp_item_type                item_in;
   logic signed [ACC_W-1:0]     xt;
   logic signed [ACC_W-1:0]     yt;
   logic signed [OUT_RND_W-1:0] xrnd;
   logic signed [OUT_RND_W-1:0] yrnd;

   always_comb begin
      l1s    = $signed({1'b0, upper_len});
      l2s    = $signed({1'b0, lower_len});
      px1_in = PROD_W'(l1s) * PROD_W'(hip_trig_ff.s);
      px2_in = PROD_W'(l2s) * PROD_W'(foot_trig_ff.s);
      py1_in = PROD_W'(l1s) * PROD_W'(hip_trig_ff.c);
      py2_in = PROD_W'(l2s) * PROD_W'(foot_trig_ff.c);
   end

   always_comb begin
      xt = ACC_W'(xr_ff) + ACC_W'(16384);
      yt = $signed({{(ACC_W - LEN_W - 16){1'b0}}, base_ff, 15'd0})
           - ACC_W'(qs_ff) + ACC_W'(16384);
      xrnd = $signed(xt[ACC_W-1:15]);
      yrnd = $signed(yt[ACC_W-1:15]);
      if (xrnd > X_HI) begin
         xrnd = X_HI;
      end else if (xrnd < X_LO) begin
         xrnd = X_LO;
      end
      if (yrnd < 0) begin
         yrnd = '0;
      end else if (yrnd > Y_HI) begin
         yrnd = Y_HI;
      end
      item_in.x_position = POS_W'(xrnd);
      item_in.y_position = POS_W'(yrnd);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= cordic_out.valid;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
         d_valid_ff <= c_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      hip_trig_ff  <= lane_trig(cordic_out.hip);
      foot_trig_ff <= lane_trig(cordic_out.foot);
      px1_ff       <= px1_in;
      px2_ff       <= px2_in;
      py1_ff       <= py1_in;
      py2_ff       <= py2_in;
      lsum_ff      <= (LEN_W + 1)'(upper_len) + (LEN_W + 1)'(lower_len);
      xr_ff        <= SUM_W'(px1_ff) + SUM_W'(px2_ff);
      qs_ff        <= SUM_W'(py1_ff) + SUM_W'(py2_ff);
      base_ff      <= lsum_ff;
      item_ff      <= item_in;
   end

   assign result.valid = d_valid_ff;
   assign result.item  = item_ff;

endmodule

/* rtl/core/tlfk_rsp_queue.sv */
// ----------------------------------------------------------------------------
// tlfk_rsp_queue
// Response queue that absorbs results while the receiver stalls.
// ----------------------------------------------------------------------------
module tlfk_rsp_queue (
   input  logic                         clock,
   input  logic                         reset,
   input  tlfk_pkg::rsp_stage_type      wr,
   tlfk_rsp_if.source                   rsp_bus,
   output tlfk_pkg::queue_status_type   status
);
   import tlfk_pkg::*;

   rsp_item_type        mem_ff [QUEUE_DEPTH];
   rsp_item_type        rd_data_ff;
   logic [QUEUE_AW-1:0] wr_ptr_ff;
   logic [QUEUE_AW-1:0] wr_ptr_in;
   logic [QUEUE_AW-1:0] rd_ptr_ff;
   logic [QUEUE_AW-1:0] rd_ptr_in;
   logic [QUEUE_AW:0]   count_ff;
   logic [QUEUE_AW:0]   count_in;
   logic                take;

   always_comb begin
      take      = rsp_bus.valid && rsp_bus.ready;
      wr_ptr_in = wr.valid ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = take ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (wr.valid && !take) begin
         count_in = count_ff + 1'b1;
      end else if (!wr.valid && take) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // head entry is read ahead; a write into the next head slot bypasses
   always_ff @(posedge clock) begin
      if (wr.valid) begin
         mem_ff[wr_ptr_ff] <= wr.item;
      end
      if (wr.valid && (wr_ptr_ff == rd_ptr_in)) begin
         rd_data_ff <= wr.item;
      end else begin
         rd_data_ff <= mem_ff[rd_ptr_in];
      end
   end

   assign rsp_bus.valid      = (count_ff != '0);
   assign rsp_bus.x_position = rd_data_ff.x_position;
   assign rsp_bus.y_position = rd_data_ff.y_position;
   assign status.count       = count_ff;
   assign status.full        = (count_ff == QUEUE_FULL);

endmodule
